@@ sv/ssk_pkg.sv @@
// Shared definitions for the sorted unique key set: request codes,
// result status codes, fixed port field widths and the cell command type.
// No dependencies.
package ssk_pkg;

   localparam int CAPACITY_DEF  = 64;
   localparam int KEY_WIDTH_DEF = 32;

   // Field widths fixed at the ports.
   localparam int KEY_PORT_W = 32;
   localparam int REQ_TYPE_W = 3;
   localparam int STATUS_W   = 2;

   typedef enum logic [REQ_TYPE_W-1:0] {
      OP_INSERT     = 3'd0,
      OP_POP_LAST   = 3'd1,
      OP_REMOVE_AT  = 3'd2,
      OP_REMOVE_VAL = 3'd3,
      OP_GET        = 3'd4,
      OP_FIND       = 3'd5
   } ssk_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_IGNORED = 2'd1,
      ST_ERROR   = 2'd2
   } ssk_status_type;

   // Update command broadcast to every cell when a request commits.
   typedef struct packed {
      logic do_insert;
      logic do_remove;
   } ssk_cmd_type;

endpackage

@@ sv/ssk_cell.sv @@
// One storage cell of the sorted key set: holds one key, compares it
// against the request key and shifts with its neighbors on update.
// Depends on ssk_pkg.
module ssk_cell import ssk_pkg::*; #(
   parameter int CAPACITY  = CAPACITY_DEF,
   parameter int KEY_WIDTH = KEY_WIDTH_DEF,
   parameter int INDEX     = 0,
   localparam int SLOT_W   = $clog2(CAPACITY),
   localparam int COUNT_W  = $clog2(CAPACITY + 1)
) (
   input  logic                        clock,
   input  logic                        capture,
   input  logic signed [KEY_WIDTH-1:0] req_key,
   input  logic [SLOT_W-1:0]           req_slot,
   input  logic                        by_index,
   input  logic [COUNT_W-1:0]          count,
   input  ssk_cmd_type                 cmd,
   input  logic signed [KEY_WIDTH-1:0] prev_key,
   input  logic                        prev_ins,
   input  logic signed [KEY_WIDTH-1:0] next_key,
   output logic signed [KEY_WIDTH-1:0] key_out,
   output logic                        ins_out,
   output logic                        eq_out,
   output logic [KEY_WIDTH-1:0]        rd_out
);

   logic signed [KEY_WIDTH-1:0] key_ff, key_in;
   logic                        ins_ff, eq_ff, del_ff, hit_ff;
   logic                        valid;

   assign valid = COUNT_W'(INDEX) < count;

   // Flags are taken when a request is accepted and held while it is evaluated.
   always_ff @(posedge clock) begin
      if (capture) begin
         ins_ff <= !valid || (req_key < key_ff);
         eq_ff  <= valid && (req_key == key_ff);
         del_ff <= by_index ? (SLOT_W'(INDEX) >= req_slot)
                            : (valid && (key_ff >= req_key));
         hit_ff <= SLOT_W'(INDEX) == req_slot;
      end
   end

   always_comb begin
      key_in = key_ff;
      if (cmd.do_insert && ins_ff) begin
         key_in = prev_ins ? prev_key : req_key;
      end else if (cmd.do_remove && del_ff) begin
         key_in = next_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key_out = key_ff;
   assign ins_out = ins_ff;
   assign eq_out  = eq_ff;
   assign rd_out  = key_ff & {KEY_WIDTH{hit_ff}};

endmodule

@@ sv/sorted_unique_key_set.sv @@
// Sorted unique key set: up to CAPACITY signed keys kept in ascending order
// in a row of cells, one key per cell. When a request is accepted, all cells
// compare its key in parallel; in the evaluation state, the result is formed
// and, for an insert or a removal by value or index, the cells shift up or
// down together. The time does not depend on how many keys are held. A new
// request is taken while the previous result still waits at the output; its
// evaluation then lasts until that result has been taken.
// Depends on ssk_pkg and ssk_cell.
module sorted_unique_key_set import ssk_pkg::*; #(
   parameter int CAPACITY  = CAPACITY_DEF,
   parameter int KEY_WIDTH = KEY_WIDTH_DEF,
   localparam int SLOT_W   = $clog2(CAPACITY),
   localparam int COUNT_W  = $clog2(CAPACITY + 1),
   localparam int REQ_W    = ((KEY_PORT_W + SLOT_W + 7) / 8) * 8,
   localparam int RSP_W    = ((KEY_PORT_W + SLOT_W + COUNT_W + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,  // key, slot
   input  logic [REQ_TYPE_W-1:0] req_tuser,  // req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,  // value_out, position, count
   output logic [STATUS_W-1:0]   rsp_tuser   // status
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EVAL = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic                        capture, commit;
   logic signed [63:0]          key_wide;
   logic signed [KEY_WIDTH-1:0] key_norm;
   logic [SLOT_W-1:0]           slot_req;
   logic                        by_index;

   logic signed [KEY_WIDTH-1:0] key_ff;
   logic [SLOT_W-1:0]           slot_ff;
   logic [REQ_TYPE_W-1:0]       op_ff;
   logic [COUNT_W-1:0]          count_ff, count_in;

   ssk_cmd_type                 cmd;
   logic signed [KEY_WIDTH-1:0] cell_key [CAPACITY];
   logic                        cell_ins [CAPACITY];
   logic                        cell_eq  [CAPACITY];
   logic [KEY_WIDTH-1:0]        cell_rd  [CAPACITY];

   logic                        any_eq;
   logic [SLOT_W-1:0]           find_pos;
   logic [KEY_WIDTH-1:0]        rd_key;
   logic signed [63:0]          rd_wide;
   logic                        slot_ok;

   ssk_status_type              status;
   logic [KEY_PORT_W-1:0]       value_res;
   logic [SLOT_W-1:0]           pos_res;

   logic                        rsp_valid_ff;
   logic [RSP_W-1:0]            rsp_data_ff;
   logic [STATUS_W-1:0]         rsp_user_ff;

   assign req_tready = state_ff == S_IDLE;
   assign capture    = req_tvalid && req_tready;
   assign commit     = (state_ff == S_EVAL) && (!rsp_valid_ff || rsp_tready);

   // The port key is cut or sign-extended to the stored key width.
   assign key_wide = 64'($signed(req_tdata[KEY_PORT_W-1:0]));
   assign key_norm = key_wide[KEY_WIDTH-1:0];
   assign slot_req = req_tdata[KEY_PORT_W +: SLOT_W];
   assign by_index = req_tuser == OP_REMOVE_AT;

   always_ff @(posedge clock) begin
      if (capture) begin
         key_ff  <= key_norm;
         slot_ff <= slot_req;
         op_ff   <= req_tuser;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [KEY_WIDTH-1:0] prev_key, next_key;
      logic                        prev_ins;

      if (i == 0) begin : g_first
         assign prev_key = cell_key[i];
         assign prev_ins = 1'b0;
      end else begin : g_mid
         assign prev_key = cell_key[i-1];
         assign prev_ins = cell_ins[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_key = cell_key[i];
      end else begin : g_inner
         assign next_key = cell_key[i+1];
      end

      ssk_cell #(
         .CAPACITY  (CAPACITY),
         .KEY_WIDTH (KEY_WIDTH),
         .INDEX     (i)
      ) u_cell (
         .clock    (clock),
         .capture  (capture),
         .req_key  (capture ? key_norm : key_ff),
         .req_slot (slot_req),
         .by_index (by_index),
         .count    (count_ff),
         .cmd      (cmd),
         .prev_key (prev_key),
         .prev_ins (prev_ins),
         .next_key (next_key),
         .key_out  (cell_key[i]),
         .ins_out  (cell_ins[i]),
         .eq_out   (cell_eq[i]),
         .rd_out   (cell_rd[i])
      );
   end

   // At most one cell matches, so the position and read data are plain ORs.
   always_comb begin
      any_eq   = 1'b0;
      find_pos = '0;
      rd_key   = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         any_eq   = any_eq | cell_eq[i];
         find_pos = find_pos | (cell_eq[i] ? SLOT_W'(i) : '0);
         rd_key   = rd_key | cell_rd[i];
      end
   end

   assign rd_wide = 64'($signed(rd_key));
   assign slot_ok = COUNT_W'(slot_ff) < count_ff;

   always_comb begin
      status        = ST_ERROR;
      value_res     = '0;
      pos_res       = '0;
      cmd.do_insert = 1'b0;
      cmd.do_remove = 1'b0;
      count_in      = count_ff;
      unique case (op_ff)
         OP_INSERT: begin
            if (any_eq) begin
               status = ST_IGNORED;
            end else if (count_ff == COUNT_W'(CAPACITY)) begin
               status = ST_ERROR;
            end else begin
               status        = ST_OK;
               cmd.do_insert = 1'b1;
               count_in      = count_ff + 1'b1;
            end
         end
         OP_POP_LAST: begin
            if (count_ff != '0) begin
               status   = ST_OK;
               count_in = count_ff - 1'b1;
            end
         end
         OP_REMOVE_AT: begin
            if (slot_ok) begin
               status        = ST_OK;
               cmd.do_remove = 1'b1;
               count_in      = count_ff - 1'b1;
            end
         end
         OP_REMOVE_VAL: begin
            if (any_eq) begin
               status        = ST_OK;
               cmd.do_remove = 1'b1;
               count_in      = count_ff - 1'b1;
            end else begin
               status = ST_IGNORED;
            end
         end
         OP_GET: begin
            if (slot_ok) begin
               status    = ST_OK;
               value_res = rd_wide[KEY_PORT_W-1:0];
            end
         end
         OP_FIND: begin
            if (any_eq) begin
               status  = ST_OK;
               pos_res = find_pos;
            end else begin
               status = ST_IGNORED;
            end
         end
         default: begin
            status = ST_ERROR;
         end
      endcase
      if (!commit) begin
         cmd.do_insert = 1'b0;
         cmd.do_remove = 1'b0;
         count_in      = count_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (capture) state_in = S_EVAL;
         end
         S_EVAL: begin
            if (commit) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_data_ff <= RSP_W'({count_in, pos_res, value_res});
         rsp_user_ff <= status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
